/* design/bsst_pkg.sv */
// ----------------------------------------------------------------------------
// bsst_pkg
// Types and constants shared by the sorted-table binary search block.
// ----------------------------------------------------------------------------
package bsst_pkg;

    localparam int DATA_W = 32;   // table entry and key width
    localparam int CNT_W  = 9;    // width of the used_count register
    localparam int IDX_W  = 8;    // width of entry_index and position
    localparam int SUM_W  = CNT_W + 1;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DONE
    } t_state;

endpackage

/* design/bsst_table.sv */
// ----------------------------------------------------------------------------
// bsst_table
// Table storage: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bsst_table #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [ADDR_W-1:0]                 i_waddr,
    input  logic [bsst_pkg::DATA_W-1:0]       i_wdata,
    input  logic                              i_re,
    input  logic [ADDR_W-1:0]                 i_raddr,
    output logic [bsst_pkg::DATA_W-1:0]       o_rdata
);

    logic [bsst_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [bsst_pkg::DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/binary_search_sorted_table.sv */
// ----------------------------------------------------------------------------
// binary_search_sorted_table
// Holds a table of signed entries, kept in ascending order by the writer, and answers searches.
// ----------------------------------------------------------------------------
// A write beat stores one entry and returns no result; the block is ready for
// the next beat in the following cycle. A search beat makes k probes, where k
// is at most floor(log2(n)) + 1 for n entries in use. The table memory has
// registered read data, and the compare of one probe picks the next midpoint
// and issues its read in the same cycle. The result beat sits in an output
// register, so a pending result does not hold up writes; but no input beat is
// taken after a search beat until its result has moved into that register,
// which waits while it still holds an earlier result that is not taken.
// Entries are undefined until written, and a search must only probe entries
// that have been written.
// ----------------------------------------------------------------------------
module binary_search_sorted_table #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [bsst_pkg::CNT_W-1:0]          i_cfg_data,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_op,
    input  logic [bsst_pkg::IDX_W-1:0]          i_entry_index,
    input  logic signed [bsst_pkg::DATA_W-1:0]  i_entry_value,
    input  logic signed [bsst_pkg::DATA_W-1:0]  i_search_key,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_found,
    output logic [bsst_pkg::IDX_W-1:0]          o_position
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = bsst_pkg::CNT_W;
    localparam int SUM_W  = bsst_pkg::SUM_W;
    localparam int IDX_W  = bsst_pkg::IDX_W;
    localparam int DATA_W = bsst_pkg::DATA_W;

    bsst_pkg::t_state r_state, n_state;

    logic [CNT_W-1:0]         r_used_count;
    logic signed [DATA_W-1:0] r_key, n_key;
    logic [CNT_W-1:0]         r_lo, n_lo;     // inclusive lower bound
    logic [CNT_W-1:0]         r_hi, n_hi;     // exclusive upper bound
    logic [CNT_W-1:0]         r_mid, n_mid;
    logic                     r_res_found, n_res_found;
    logic [IDX_W-1:0]         r_res_pos, n_res_pos;
    logic                     r_out_valid, n_out_valid;
    logic                     r_found, n_found;
    logic [IDX_W-1:0]         r_position, n_position;

    logic                     in_beat;
    logic [CNT_W-1:0]         n_clamped;
    logic [CNT_W-1:0]         lo_sel, hi_sel;
    logic [SUM_W-1:0]         mid_sum;
    logic [CNT_W-1:0]         mid_calc;
    logic                     wr_en;
    logic                     rd_en;
    logic [DATA_W-1:0]        rd_data_raw;
    logic signed [DATA_W-1:0] rd_data;

    assign in_beat = i_in_valid && o_in_ready;
    assign rd_data = $signed(rd_data_raw);

    // A count beyond the table depth searches the whole table.
    always_comb begin
        if (32'(r_used_count) > TABLE_DEPTH) begin
            n_clamped = CNT_W'(TABLE_DEPTH);
        end else begin
            n_clamped = r_used_count;
        end
    end

    // Midpoint of the bounds that the current cycle selects; lo < hi holds
    // whenever this is used, so the subtraction cannot wrap.
    assign mid_sum  = SUM_W'(lo_sel) + SUM_W'(hi_sel) - SUM_W'(1);
    assign mid_calc = mid_sum[SUM_W-1:1];

    assign wr_en = in_beat && (i_op == bsst_pkg::OP_WRITE) &&
                   (32'(i_entry_index) < TABLE_DEPTH);

    bsst_table #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (ADDR_W'(i_entry_index)),
        .i_wdata (i_entry_value),
        .i_re    (rd_en),
        .i_raddr (ADDR_W'(mid_calc)),
        .o_rdata (rd_data_raw)
    );

    always_comb begin
        n_state     = r_state;
        n_key       = r_key;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_res_found = r_res_found;
        n_res_pos   = r_res_pos;
        n_out_valid = r_out_valid;
        n_found     = r_found;
        n_position  = r_position;
        o_in_ready  = 1'b0;
        rd_en       = 1'b0;
        lo_sel      = r_lo;
        hi_sel      = r_hi;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            bsst_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                lo_sel     = '0;
                hi_sel     = n_clamped;
                if (i_in_valid && (i_op == bsst_pkg::OP_SEARCH)) begin
                    n_key = i_search_key;
                    n_lo  = '0;
                    n_hi  = n_clamped;
                    if (n_clamped == '0) begin
                        n_res_found = 1'b0;
                        n_res_pos   = '0;
                        n_state     = bsst_pkg::ST_DONE;
                    end else begin
                        rd_en   = 1'b1;
                        n_mid   = mid_calc;
                        n_state = bsst_pkg::ST_SEARCH;
                    end
                end
            end
            bsst_pkg::ST_SEARCH: begin
                if (rd_data < r_key) begin
                    lo_sel = r_mid + CNT_W'(1);
                end else if (rd_data > r_key) begin
                    hi_sel = r_mid;
                end
                n_lo = lo_sel;
                n_hi = hi_sel;
                if (rd_data == r_key) begin
                    n_res_found = 1'b1;
                    n_res_pos   = r_mid[IDX_W-1:0];
                    n_state     = bsst_pkg::ST_DONE;
                end else if (lo_sel < hi_sel) begin
                    rd_en = 1'b1;
                    n_mid = mid_calc;
                end else begin
                    n_res_found = 1'b0;
                    n_res_pos   = '0;
                    n_state     = bsst_pkg::ST_DONE;
                end
            end
            bsst_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_found     = r_res_found;
                    n_position  = r_res_pos;
                    n_state     = bsst_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bsst_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= bsst_pkg::ST_IDLE;
            r_out_valid  <= 1'b0;
            r_used_count <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_used_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_mid       <= n_mid;
        r_res_found <= n_res_found;
        r_res_pos   <= n_res_pos;
        r_found     <= n_found;
        r_position  <= n_position;
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_position  = r_position;

endmodule

/* design/bsst_checker.sv */
// ----------------------------------------------------------------------------
// bsst_checker
// Port-level checks of the sorted-table binary search block.
// ----------------------------------------------------------------------------
module bsst_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          i_op,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic                          o_found,
    input logic [bsst_pkg::IDX_W-1:0]    o_position
);

    // A result beat that is not taken stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_found) && $stable(o_position))
        else $error("result beat changed while stalled");

    // A miss always reports position zero.
    a_miss_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_position == '0)
        else $error("miss reported with nonzero position");

    // A write beat never produces a result beat.
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_op == bsst_pkg::OP_WRITE) && !o_out_valid
            |=> !o_out_valid)
        else $error("write beat produced a result");

    // The block is busy in the cycle after it takes a search beat.
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_op == bsst_pkg::OP_SEARCH) |=> !o_in_ready)
        else $error("input taken during a search");

endmodule

bind binary_search_sorted_table bsst_checker u_bsst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_op        (i_op),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_found     (o_found),
    .o_position  (o_position)
);

/* test/tb_binary_search_sorted_table.sv */
// ----------------------------------------------------------------------------
// tb_binary_search_sorted_table
// Self-checking bench for the sorted-table binary search block. A queue of
// write and search beats feeds a driver. Each taken write updates a mirror
// of the table, and each search beat is predicted by a probe-for-probe copy of
// the search. A monitor checks result beats in order. Phases change the entry
// count while the block is idle, and both channels stall in random bursts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_binary_search_sorted_table;

    localparam int DATA_W        = bsst_pkg::DATA_W;
    localparam int CNT_W         = bsst_pkg::CNT_W;
    localparam int IDX_W         = bsst_pkg::IDX_W;
    localparam int TABLE_DEPTH   = 256;
    localparam int ITEM_TARGET   = 900;
    localparam int SETTLE_CYCLES = 16;
    localparam int QUIET_LIMIT   = 2000;
    localparam logic [DATA_W-1:0] MIN_VAL = 32'h8000_0000;
    localparam logic [DATA_W-1:0] MAX_VAL = 32'h7FFF_FFFF;
    localparam logic [CNT_W-1:0]  CNT_MAX = '1;

    typedef struct packed {
        logic              op;
        logic [IDX_W-1:0]  index;
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] key;
    } t_table_beat;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] position;
    } t_lookup_answer;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [CNT_W-1:0]  cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic              op = bsst_pkg::OP_WRITE;
    logic [IDX_W-1:0]  entry_index = '0;
    logic [DATA_W-1:0] entry_value = '0;
    logic [DATA_W-1:0] search_key = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              found;
    logic [IDX_W-1:0]  position;

    // Stimulus side: beats waiting for the driver and the planned table.
    t_table_beat       pending_beats[$];
    t_table_beat       drive_beat;
    logic [DATA_W-1:0] plan_table [TABLE_DEPTH];
    bit                plan_written [TABLE_DEPTH];
    int                item_count = 0;
    int                beats_queued = 0;
    bit                idle_on = 1'b1;
    int                send_gap = 0;
    int                stall_left = 0;

    // Checking side: mirror of the block's state and pending answers.
    logic signed [DATA_W-1:0] table_mirror [TABLE_DEPTH];
    logic [CNT_W-1:0]  count_mirror = '0;
    t_lookup_answer    lookup_answers[$];
    t_lookup_answer    want;
    int                beats_taken = 0;
    bit                in_beat_taken = 1'b0;
    int                quiet_cycles = 0;
    int                mismatch_count = 0;

    binary_search_sorted_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) uut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_op         (op),
        .i_entry_index(entry_index),
        .i_entry_value(entry_value),
        .i_search_key (search_key),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_found      (found),
        .o_position   (position)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Same probe sequence as the block: midpoint rounded down, stop on equal.
    function automatic t_lookup_answer search_table(input logic signed [DATA_W-1:0] key);
        t_lookup_answer ans;
        int lo;
        int hi;
        int mid;
        ans = '0;
        lo = 0;
        hi = ((count_mirror > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_mirror)) - 1;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (table_mirror[mid] == key) begin
                ans.found = 1'b1;
                ans.position = mid[IDX_W-1:0];
                return ans;
            end
            if (table_mirror[mid] < key) begin
                lo = mid + 1;
            end else begin
                hi = mid - 1;
            end
        end
        return ans;
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] exp_val);
        mismatch_count++;
        $display("%0t: %s: got %0h, expected %0h", $time, what, got, exp_val);
    endtask

    task automatic queue_write(input int idx, input logic [DATA_W-1:0] val);
        t_table_beat b;
        b.op = bsst_pkg::OP_WRITE;
        b.index = idx[IDX_W-1:0];
        b.value = val;
        b.key = $urandom;
        pending_beats.push_back(b);
        plan_table[idx] = val;
        plan_written[idx] = 1'b1;
        item_count++;
        beats_queued++;
    endtask

    task automatic queue_search(input logic [DATA_W-1:0] key);
        t_table_beat b;
        b.op = bsst_pkg::OP_SEARCH;
        b.index = IDX_W'($urandom);
        b.value = $urandom;
        b.key = key;
        pending_beats.push_back(b);
        item_count++;
        beats_queued++;
    endtask

    task automatic wait_drained();
        while (beats_queued != beats_taken || lookup_answers.size() != 0) begin
            @(negedge clk);
        end
    endtask

    // The register is only touched once every beat is taken, every answer
    // is back and the last search has had time to finish.
    task automatic set_used_count(input logic [CNT_W-1:0] n);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= n;
        count_mirror = n;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Ascending content; the step size picks dense duplicates, a narrow
    // spread or the whole signed range.
    task automatic fill_table(input int nn);
        longint cur;
        longint step_max;
        int mode;
        int a;
        int b;
        logic [DATA_W-1:0] vals [TABLE_DEPTH];
        logic [DATA_W-1:0] tmp;
        mode = $urandom_range(0, 2);
        case (mode)
            0: begin
                cur = longint'($urandom_range(0, 40)) - 20;
                step_max = 3;
            end
            1: begin
                cur = longint'($signed($urandom));
                step_max = 1000;
            end
            default: begin
                cur = -64'sd2147483648;
                step_max = 64'sd4294967295 / nn;
            end
        endcase
        for (int i = 0; i < nn; i++) begin
            if (cur > 64'sd2147483647) begin
                cur = 64'sd2147483647;
            end
            vals[i] = cur[DATA_W-1:0];
            cur = cur + longint'($urandom_range(0, 32'(step_max)));
        end
        if (mode == 2 && nn > 1) begin
            vals[nn-1] = MAX_VAL;
        end
        // Now and then the table is left out of order.
        if (nn > 1 && $urandom_range(0, 15) == 0) begin
            a = $urandom_range(0, nn - 1);
            b = $urandom_range(0, nn - 1);
            tmp = vals[a];
            vals[a] = vals[b];
            vals[b] = tmp;
        end
        for (int i = 0; i < nn; i++) begin
            queue_write(i, vals[i]);
        end
    endtask

    function automatic logic [DATA_W-1:0] pick_key(input int nn);
        logic [DATA_W-1:0] k;
        int r;
        r = $urandom_range(0, 9);
        if (nn == 0 || r >= 8) begin
            k = $urandom;
        end else begin
            k = plan_table[$urandom_range(0, nn - 1)];
            if (r == 6) begin
                k = k + 1;
            end else if (r == 7) begin
                k = k - 1;
            end
        end
        return k;
    endfunction

    task automatic run_searches(input int nn, input int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                queue_write($urandom_range(0, TABLE_DEPTH - 1), $urandom);
            end else begin
                queue_search(pick_key(nn));
            end
        end
    endtask

    initial begin : stimulus
        int n;
        int nn;
        int phase_no;
        bit covered;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Empty table.
        set_used_count('0);
        queue_search(32'h0);
        queue_search(MIN_VAL);
        queue_search(MAX_VAL);

        // Extremes, duplicates, then an out-of-order entry.
        queue_write(0, MIN_VAL);
        queue_write(1, 32'hFFFF_FFFF);
        queue_write(2, 32'h0);
        queue_write(3, 32'h1);
        queue_write(4, 32'h5);
        queue_write(5, 32'h5);
        queue_write(6, 32'h5);
        queue_write(7, MAX_VAL);
        queue_write(TABLE_DEPTH - 1, MAX_VAL);
        set_used_count(CNT_W'(8));
        queue_search(MIN_VAL);
        queue_search(32'hFFFF_FFFF);
        queue_search(32'h0);
        queue_search(32'h1);
        queue_search(32'h5);
        queue_search(MAX_VAL);
        queue_search(32'h3);
        queue_search(32'hFFFF_FFFE);
        queue_write(2, 32'd100);
        queue_search(32'd100);
        queue_search(32'h1);

        phase_no = 0;
        while (item_count < ITEM_TARGET) begin
            case (phase_no)
                0: n = 0;
                1: n = 1;
                2: n = 2;
                3: n = TABLE_DEPTH;
                4: n = int'(CNT_MAX);
                default: n = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 255)
                                                         : $urandom_range(0, 40);
            endcase
            nn = (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
            set_used_count(n[CNT_W-1:0]);
            // Quiet stretches, and none at all near the end.
            idle_on = (item_count < ITEM_TARGET - 150) && ($urandom_range(0, 3) != 0);
            covered = 1'b1;
            for (int i = 0; i < nn; i++) begin
                if (!plan_written[i]) begin
                    covered = 1'b0;
                end
            end
            if (!covered || (nn <= 64 && $urandom_range(0, 3) != 0)) begin
                fill_table(nn);
            end
            run_searches(nn, $urandom_range(10, 40));
            phase_no++;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && lookup_answers.size() == 0) begin
            $display("binary_search_sorted_table: match");
        end else begin
            $display("binary_search_sorted_table: mismatch");
        end
        $finish;
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && !in_beat_taken) begin
            // Hold the beat until it is taken.
        end else if (send_gap > 0) begin
            send_gap--;
            in_valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(0, 9);
            in_valid <= 1'b0;
        end else if (pending_beats.size() != 0) begin
            drive_beat = pending_beats.pop_front();
            in_valid <= 1'b1;
            op <= drive_beat.op;
            entry_index <= drive_beat.index;
            entry_value <= drive_beat.value;
            search_key <= drive_beat.key;
        end else begin
            in_valid <= 1'b0;
        end
    end

    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 9);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            in_beat_taken = 1'b0;
        end else begin
            in_beat_taken = in_valid && in_ready;
            if (in_beat_taken) begin
                beats_taken++;
                if (op == bsst_pkg::OP_WRITE) begin
                    table_mirror[entry_index] = entry_value;
                end else begin
                    lookup_answers.push_back(search_table(search_key));
                end
            end
            if (out_valid && out_ready) begin
                if (lookup_answers.size() == 0) begin
                    report_mismatch("result beat with no search pending", 32'(position), '0);
                end else begin
                    want = lookup_answers.pop_front();
                    if (found !== want.found) begin
                        report_mismatch("found", 32'(found), 32'(want.found));
                    end
                    if (position !== want.position) begin
                        report_mismatch("position", 32'(position), 32'(want.position));
                    end
                end
            end
            if (in_beat_taken || (out_valid && out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
    end

    initial begin : watchdog
        @(posedge clk);
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge clk);
        end
        $display("binary_search_sorted_table: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
design/bsst_pkg.sv
design/bsst_table.sv
design/binary_search_sorted_table.sv
design/bsst_checker.sv
test/tb_binary_search_sorted_table.sv
